### rtl/sc1a_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sc1a_pkg
// Shared types, constants and the key map of the set 1 scancode decoder.
// ----------------------------------------------------------------------------
package sc1a_pkg;

  localparam logic [7:0] PREFIX_BYTE = 8'hE0;
  localparam logic [6:0] LEFT_SHIFT  = 7'h2A;
  localparam logic [6:0] RIGHT_SHIFT = 7'h36;
  localparam int unsigned RELEASE_BIT = 7;

  typedef struct packed {
    logic       event_valid;
    logic [6:0] key_code;
    logic       key_pressed;
    logic       key_extended;
    logic [6:0] ascii_char;
  } sc1a_result_t;

  function automatic logic [6:0] key_to_ascii(input logic [6:0] code, input logic shift);
    logic [7:0] plain;
    logic [7:0] upper;
    plain = 8'h00;
    upper = 8'h00;
    case (code)
      7'h1E: begin plain = "a"; upper = "A"; end
      7'h30: begin plain = "b"; upper = "B"; end
      7'h2E: begin plain = "c"; upper = "C"; end
      7'h20: begin plain = "d"; upper = "D"; end
      7'h12: begin plain = "e"; upper = "E"; end
      7'h21: begin plain = "f"; upper = "F"; end
      7'h22: begin plain = "g"; upper = "G"; end
      7'h23: begin plain = "h"; upper = "H"; end
      7'h17: begin plain = "i"; upper = "I"; end
      7'h24: begin plain = "j"; upper = "J"; end
      7'h25: begin plain = "k"; upper = "K"; end
      7'h26: begin plain = "l"; upper = "L"; end
      7'h32: begin plain = "m"; upper = "M"; end
      7'h31: begin plain = "n"; upper = "N"; end
      7'h18: begin plain = "o"; upper = "O"; end
      7'h19: begin plain = "p"; upper = "P"; end
      7'h10: begin plain = "q"; upper = "Q"; end
      7'h13: begin plain = "r"; upper = "R"; end
      7'h1F: begin plain = "s"; upper = "S"; end
      7'h14: begin plain = "t"; upper = "T"; end
      7'h16: begin plain = "u"; upper = "U"; end
      7'h2F: begin plain = "v"; upper = "V"; end
      7'h11: begin plain = "w"; upper = "W"; end
      7'h2D: begin plain = "x"; upper = "X"; end
      7'h15: begin plain = "y"; upper = "Y"; end
      7'h2C: begin plain = "z"; upper = "Z"; end
      7'h02: begin plain = "1"; upper = "!"; end
      7'h03: begin plain = "2"; upper = "@"; end
      7'h04: begin plain = "3"; upper = "#"; end
      7'h05: begin plain = "4"; upper = "$"; end
      7'h06: begin plain = "5"; upper = "%"; end
      7'h07: begin plain = "6"; upper = "^"; end
      7'h08: begin plain = "7"; upper = "&"; end
      7'h09: begin plain = "8"; upper = "*"; end
      7'h0A: begin plain = "9"; upper = "("; end
      7'h0B: begin plain = "0"; upper = ")"; end
      7'h1C: begin plain = 8'h0A; upper = 8'h0A; end
      7'h39: begin plain = " "; upper = " "; end
      7'h0E: begin plain = 8'h08; upper = 8'h08; end
      default: begin plain = 8'h00; upper = 8'h00; end
    endcase
    return shift ? upper[6:0] : plain[6:0];
  endfunction

endpackage
`default_nettype wire

### rtl/scancode_set1_to_ascii.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scancode_set1_to_ascii
// Set 1 scancode byte to key event and ASCII character decoder.
// ----------------------------------------------------------------------------
// One scancode byte per beat goes in, one key event per beat comes out, in
// order. The block takes a byte every cycle while the input is not stalled;
// a byte goes through an input register and then a result register, where its
// event shows. A stalled result beat holds a full input register and stalls
// the input. An 0xE0 prefix gives an event with event_valid low and all
// fields zero, and marks the next key as extended. Shift state follows the
// left and right shift keys and picks the shifted character map.
module scancode_set1_to_ascii
  import sc1a_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] scan_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            event_valid,
  output logic [6:0]      key_code,
  output logic            key_pressed,
  output logic            key_extended,
  output logic [6:0]      ascii_char
);

  logic         in_full;
  logic [7:0]   in_byte;
  logic         out_free;
  logic         advance;
  sc1a_result_t result;
  sc1a_result_t out_reg;

  assign out_free = ~out_valid | ~out_stall;
  assign advance  = in_full & out_free;
  assign in_stall = in_full & ~out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (~in_stall) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte <= scan_byte;
    end
  end

  sc1a_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .scan_byte (in_byte),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= in_full;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_reg <= result;
    end
  end

  assign event_valid  = out_reg.event_valid;
  assign key_code     = out_reg.key_code;
  assign key_pressed  = out_reg.key_pressed;
  assign key_extended = out_reg.key_extended;
  assign ascii_char   = out_reg.ascii_char;

endmodule
`default_nettype wire

### rtl/sc1a_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sc1a_decode
// Decodes one scancode byte and keeps the prefix and shift flags.
// ----------------------------------------------------------------------------
module sc1a_decode
  import sc1a_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         advance,
  input  wire logic [7:0]   scan_byte,
  output sc1a_result_t      result
);

  logic       prefix_seen;
  logic       shift_held;
  logic       prefix_seen_next;
  logic       shift_held_next;
  logic       is_prefix;
  logic [6:0] code;
  logic       pressed;
  logic       is_shift;

  assign is_prefix = (scan_byte == PREFIX_BYTE);
  assign code      = scan_byte[6:0];
  assign pressed   = ~scan_byte[RELEASE_BIT];
  assign is_shift  = (code == LEFT_SHIFT) || (code == RIGHT_SHIFT);

  always_comb begin
    prefix_seen_next = prefix_seen;
    shift_held_next  = shift_held;
    result           = '0;
    if (is_prefix) begin
      prefix_seen_next = 1'b1;
    end else begin
      prefix_seen_next    = 1'b0;
      result.event_valid  = 1'b1;
      result.key_code     = code;
      result.key_pressed  = pressed;
      result.key_extended = prefix_seen;
      if (is_shift) begin
        shift_held_next = pressed;
      end else if (pressed) begin
        result.ascii_char = key_to_ascii(code, shift_held);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_seen <= 1'b0;
      shift_held  <= 1'b0;
    end else if (advance) begin
      prefix_seen <= prefix_seen_next;
      shift_held  <= shift_held_next;
    end
  end

endmodule
`default_nettype wire

### rtl/sc1a_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sc1a_checker
// Port-level checks of the scancode decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sc1a_checker
  import sc1a_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [7:0] scan_byte,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       event_valid,
  input wire logic [6:0] key_code,
  input wire logic       key_pressed,
  input wire logic       key_extended,
  input wire logic [6:0] ascii_char
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_valid) && $stable(key_code)
      && $stable(key_pressed) && $stable(key_extended) && $stable(ascii_char))
    else $error("stalled result beat changed");

  a_prefix_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !event_valid |-> key_code == 7'h00 && !key_pressed && !key_extended
      && ascii_char == 7'h00)
    else $error("prefix beat carries nonzero fields");

  a_release_no_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && !key_pressed |-> ascii_char == 7'h00)
    else $error("release beat carries a character");

  a_shift_no_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && (key_code == LEFT_SHIFT || key_code == RIGHT_SHIFT) |-> ascii_char == 7'h00)
    else $error("shift key beat carries a character");

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result beat right after reset");

endmodule

bind scancode_set1_to_ascii sc1a_checker u_sc1a_checker (.*);
`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set 1 scancode to ASCII decoder.
// ----------------------------------------------------------------------------
// Feeds raw scancode bytes: a directed run over prefix, shift, release,
// extended and unmapped keys, then random keystrokes mixed with raw bytes.
// A scoreboard tracks prefix and shift state, predicts one key event per
// accepted byte and compares every output beat field by field, in order.
// Sender bursts and receiver stalls are random; one long receiver hold backs
// up the block, and sender pauses let the pipeline drain.
module tb_top;
  import sc1a_pkg::*;

  localparam int N_RANDOM    = 1500;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_LIMIT  = 1000;
  localparam int TAIL_CYCLES = 8;

  class key_event_board;
    bit             prefix_pending;
    bit             shift_down;
    sc1a_result_t   pending_q[$];
    bit [6:0]       plain_map[128];
    bit [6:0]       upper_map[128];
    int             errors;

    function new();
      string    letters;
      string    digits;
      string    shifted;
      bit [6:0] letter_codes[26];
      letter_codes = '{7'h1E, 7'h30, 7'h2E, 7'h20, 7'h12, 7'h21, 7'h22, 7'h23,
                       7'h17, 7'h24, 7'h25, 7'h26, 7'h32, 7'h31, 7'h18, 7'h19,
                       7'h10, 7'h13, 7'h1F, 7'h14, 7'h16, 7'h2F, 7'h11, 7'h2D,
                       7'h15, 7'h2C};
      letters = "abcdefghijklmnopqrstuvwxyz";
      digits  = "1234567890";
      shifted = "!@#$%^&*()";
      foreach (plain_map[i]) begin
        plain_map[i] = '0;
        upper_map[i] = '0;
      end
      for (int i = 0; i < 26; i++) begin
        plain_map[letter_codes[i]] = 7'(letters[i]);
        upper_map[letter_codes[i]] = 7'(letters[i] - 8'd32);
      end
      for (int i = 0; i < 10; i++) begin
        plain_map[i + 2] = 7'(digits[i]);
        upper_map[i + 2] = 7'(shifted[i]);
      end
      plain_map[7'h1C] = 7'h0A;
      upper_map[7'h1C] = 7'h0A;
      plain_map[7'h39] = 7'h20;
      upper_map[7'h39] = 7'h20;
      plain_map[7'h0E] = 7'h08;
      upper_map[7'h0E] = 7'h08;
      prefix_pending = 1'b0;
      shift_down     = 1'b0;
      errors         = 0;
    endfunction

    function void note_byte(logic [7:0] b);
      sc1a_result_t ev;
      ev = '0;
      if (b == PREFIX_BYTE) begin
        prefix_pending = 1'b1;
      end else begin
        ev.event_valid  = 1'b1;
        ev.key_code     = b[6:0];
        ev.key_pressed  = ~b[RELEASE_BIT];
        ev.key_extended = prefix_pending;
        prefix_pending  = 1'b0;
        if (b[6:0] == LEFT_SHIFT || b[6:0] == RIGHT_SHIFT) begin
          shift_down = ev.key_pressed;
        end else if (ev.key_pressed) begin
          ev.ascii_char = shift_down ? upper_map[b[6:0]] : plain_map[b[6:0]];
        end
      end
      pending_q.push_back(ev);
    endfunction

    function void check_event(sc1a_result_t got);
      sc1a_result_t want;
      if (pending_q.size() == 0) begin
        $error("key event with nothing pending: %p", got);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.event_valid !== want.event_valid) begin
        $error("event_valid: expected %0h, got %0h", want.event_valid, got.event_valid);
        errors++;
      end
      if (got.key_code !== want.key_code) begin
        $error("key_code: expected %0h, got %0h", want.key_code, got.key_code);
        errors++;
      end
      if (got.key_pressed !== want.key_pressed) begin
        $error("key_pressed: expected %0h, got %0h", want.key_pressed, got.key_pressed);
        errors++;
      end
      if (got.key_extended !== want.key_extended) begin
        $error("key_extended: expected %0h, got %0h", want.key_extended, got.key_extended);
        errors++;
      end
      if (got.ascii_char !== want.ascii_char) begin
        $error("ascii_char: expected %0h, got %0h", want.ascii_char, got.ascii_char);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] scan_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       event_valid;
  logic [6:0] key_code;
  logic       key_pressed;
  logic       key_extended;
  logic [6:0] ascii_char;

  key_event_board board = new();
  int  bytes_sent = 0;
  int  burst_left = 0;
  int  idle_cycles = 0;
  bit  hold_done = 1'b0;

  scancode_set1_to_ascii u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .scan_byte   (scan_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_valid (event_valid),
    .key_code    (key_code),
    .key_pressed (key_pressed),
    .key_extended(key_extended),
    .ascii_char  (ascii_char)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      board.note_byte(scan_byte);
    end
  end

  always @(posedge clk) begin
    sc1a_result_t got;
    if (!rst && out_valid && !out_stall) begin
      got.event_valid  = event_valid;
      got.key_code     = key_code;
      got.key_pressed  = key_pressed;
      got.key_extended = key_extended;
      got.ascii_char   = ascii_char;
      board.check_event(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL scancode_set1_to_ascii");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall pattern, plus one long hold once traffic is flowing.
  initial begin
    int hold_left;
    int span;
    int mode;
    hold_left = 0;
    span = 0;
    mode = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (!hold_done && bytes_sent >= 400) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        if (span == 0) begin
          mode = $urandom_range(0, 2);
          span = $urandom_range(5, 40);
        end
        span--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          default: out_stall <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    scan_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic drain_events();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending_q.size() != 0);
  endtask

  task automatic send_keystroke();
    logic [6:0] code;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      code = $urandom_range(0, 1) ? LEFT_SHIFT : RIGHT_SHIFT;
    end else begin
      do code = 7'($urandom_range(0, 127));
      while (board.plain_map[code] == 0 && $urandom_range(0, 3) != 0);
    end
    if ($urandom_range(0, 3) == 0) begin
      send_byte(PREFIX_BYTE);
    end
    send_byte({1'b0, code});
    if ($urandom_range(0, 4) != 0) begin
      if ($urandom_range(0, 3) == 0) begin
        send_byte(PREFIX_BYTE);
      end
      send_byte({1'b1, code});
    end
  endtask

  initial begin
    logic [7:0] directed[$];
    int         pick;
    directed = '{8'hE0, 8'h1C, 8'h00, 8'hFF, 8'h7F, 8'h80, 8'h2A, 8'h1E,
                 8'h02, 8'hE0, 8'hE0, 8'h36, 8'h0B, 8'hE0, 8'hB6, 8'h1E,
                 8'h9E, 8'h39, 8'h0E, 8'hAA, 8'h01, 8'hE0, 8'hFF, 8'h1C};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    foreach (directed[i]) begin
      send_byte(directed[i]);
    end
    drain_events();
    while (bytes_sent < directed.size() + N_RANDOM) begin
      if (bytes_sent >= 900 && bytes_sent < 910) begin
        drain_events();
      end
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (pick == 2) begin
        send_byte(PREFIX_BYTE);
      end else begin
        send_keystroke();
      end
    end
    drain_events();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("PASS scancode_set1_to_ascii");
    end else begin
      $display("FAIL scancode_set1_to_ascii");
    end
    $finish;
  end

endmodule

### sim.f
rtl/sc1a_pkg.sv
rtl/sc1a_decode.sv
rtl/scancode_set1_to_ascii.sv
rtl/sc1a_checker.sv
dv/tb_top.sv
